[design/mts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned FILL_W  = 7;
	localparam int unsigned ERR_W   = 2;

	// command codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// error codes
	localparam logic [ERR_W-1:0] ERR_OK         = 2'd0;
	localparam logic [ERR_W-1:0] ERR_POP_EMPTY  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_PUSH_FULL  = 2'd2;

	// one stack entry: the value and the running minimum when it was pushed
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] run_min;
	} entry_t;

	// shift control broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} shift_t;

endpackage

`default_nettype wire

[design/min_tracking_stack_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// min tracking stack: a lifo of signed 32-bit values that also gives the
// minimum of all held values at once. a command (push or pop) is one
// transaction, taken at a rising edge with start high and busy low; busy
// is always low, so a new command may be issued every cycle. the result of
// each command appears on the result ports for exactly one cycle, marked by
// done, in the cycle right after the command was taken, at a throughput of
// one command per cycle. the receiver cannot stall and must take every
// result when done is high. the stack is a row of STACK_DEPTH cells,
// cell 0 is the top; every push shifts the whole row down by one cell and
// every pop shifts it up, so the top entry and its running minimum are
// always in cell 0. a pop on an empty stack and a push on a full stack
// leave the stack unchanged and report an error code. top_value and
// min_value read 0 while the stack is empty; fill_count is the held count
// taken modulo 128.
module min_tracking_stack_unit #(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                cmd,
	input  wire logic signed [mts_pkg::DATA_W-1:0]   push_value,
	output logic                                     done,
	output logic signed [mts_pkg::DATA_W-1:0]        top_value,
	output logic signed [mts_pkg::DATA_W-1:0]        min_value,
	output logic [mts_pkg::FILL_W-1:0]               fill_count,
	output logic                                     is_empty,
	output logic [mts_pkg::ERR_W-1:0]                error_code
);

	// pointer wide enough to hold the depth itself
	localparam int unsigned PTR_W = $clog2(STACK_DEPTH + 1);

	logic [PTR_W-1:0]                count_q;
	logic                            done_q;
	logic [mts_pkg::ERR_W-1:0]       err_q;

	mts_pkg::entry_t                 cells [STACK_DEPTH];
	mts_pkg::entry_t                 new_entry;
	mts_pkg::shift_t                 ctrl;

	logic                            accept;
	logic                            stack_empty;
	logic                            stack_full;

	// commands never wait: busy is tied low
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign stack_empty = (count_q == '0);
	assign stack_full  = (count_q == PTR_W'(STACK_DEPTH));

	// shift control, with the error cases turned into no-ops
	always_comb begin
		ctrl.push = accept && (cmd == mts_pkg::CMD_PUSH) && !stack_full;
		ctrl.pop  = accept && (cmd == mts_pkg::CMD_POP) && !stack_empty;
	end

	// entry entering the top cell: running min against the current top
	always_comb begin
		new_entry.value   = push_value;
		new_entry.run_min = push_value;
		if (!stack_empty && (cells[0].run_min < push_value)) begin
			new_entry.run_min = cells[0].run_min;
		end
	end

	// the row of cells, top at index 0
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		mts_pkg::entry_t above;
		mts_pkg::entry_t below;

		if (i == 0) begin : g_top
			assign above = new_entry;
		end else begin : g_mid
			assign above = cells[i-1];
		end

		// nothing comes up from below the deepest cell
		if (i == STACK_DEPTH - 1) begin : g_bottom
			assign below = '0;
		end else begin : g_inner
			assign below = cells[i+1];
		end

		mts_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.from_above (above),
			.from_below (below),
			.entry      (cells[i])
		);
	end

	// fill count, result strobe and error code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
			err_q   <= mts_pkg::ERR_OK;
		end else begin
			done_q <= accept;
			if (ctrl.push) begin
				count_q <= count_q + PTR_W'(1);
			end else if (ctrl.pop) begin
				count_q <= count_q - PTR_W'(1);
			end
			if (accept) begin
				if (cmd == mts_pkg::CMD_PUSH) begin
					err_q <= stack_full ? mts_pkg::ERR_PUSH_FULL : mts_pkg::ERR_OK;
				end else begin
					err_q <= stack_empty ? mts_pkg::ERR_POP_EMPTY : mts_pkg::ERR_OK;
				end
			end
		end
	end

	// results come straight from the updated state, the top cell holds
	// both the top value and the current minimum
	logic [PTR_W+mts_pkg::FILL_W-1:0] count_ext;

	assign count_ext  = {{mts_pkg::FILL_W{1'b0}}, count_q};
	assign done       = done_q;
	assign is_empty   = stack_empty;
	assign top_value  = stack_empty ? '0 : cells[0].value;
	assign min_value  = stack_empty ? '0 : cells[0].run_min;
	assign fill_count = count_ext[mts_pkg::FILL_W-1:0];
	assign error_code = err_q;

endmodule

`default_nettype wire

[design/mts_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module mts_cell (
	input  wire logic            clk,
	input  wire mts_pkg::shift_t ctrl,
	input  wire mts_pkg::entry_t from_above,
	input  wire mts_pkg::entry_t from_below,
	output mts_pkg::entry_t      entry
);

	mts_pkg::entry_t entry_q;

	// push moves everything one cell deeper, pop pulls everything one cell up
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			entry_q <= from_above;
		end else if (ctrl.pop) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire
